// ===== hw/rtl/gfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// gfpa_pkg
// Field types, GF(2^113) arithmetic and the stage schedule of the adder.
// ----------------------------------------------------------------------------
package gfpa_pkg;

    localparam int FE_W   = 113;
    localparam int HI_W   = 49;
    localparam int LO_W   = 64;
    localparam int A_W    = 32;
    localparam int PROD_W = 2 * FE_W - 1;
    localparam int MAX_SQ = 8;

    typedef logic [FE_W-1:0] fe_t;

    typedef enum logic [2:0] {
        OP_LOADSQ,   // sh = acc^(2^n)
        OP_SQ,       // sh = sh^(2^n)
        OP_MULAS,    // acc = acc * sh
        OP_SQMULU,   // acc = acc^2 * u
        OP_LAM,      // acc = acc^2 * ys  (final inverse square, then lambda)
        OP_X,        // sh = lam^2 + lam + x2 + a ; px = sh + x1
        OP_Y         // py = lam * sh + px + py
    } op_t;

    typedef struct packed {
        fe_t u;
        fe_t ys;
        fe_t px;
        fe_t py;
        fe_t qx;
        fe_t acc;
        fe_t sh;
    } word_t;

    localparam int NSTG = 27;

    localparam op_t STG_OP [NSTG] = '{
        OP_LOADSQ, OP_MULAS, OP_SQMULU,
        OP_LOADSQ, OP_MULAS, OP_SQMULU,
        OP_LOADSQ, OP_MULAS,
        OP_LOADSQ, OP_SQ, OP_MULAS,
        OP_LOADSQ, OP_SQ, OP_SQ, OP_SQ, OP_MULAS,
        OP_LOADSQ, OP_SQ, OP_SQ, OP_SQ, OP_SQ, OP_SQ, OP_SQ, OP_MULAS,
        OP_LAM, OP_X, OP_Y
    };

    localparam logic [3:0] STG_NSQ [NSTG] = '{
        4'd1, 4'd0, 4'd0,
        4'd3, 4'd0, 4'd0,
        4'd7, 4'd0,
        4'd8, 4'd6, 4'd0,
        4'd8, 4'd8, 4'd8, 4'd4, 4'd0,
        4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0,
        4'd0, 4'd0, 4'd0
    };

    // fold modulo t^113 + t^9 + 1, two passes
    function automatic fe_t fe_reduce(input logic [PROD_W-1:0] p);
        logic [FE_W-2:0] h1;
        logic [FE_W+7:0] r1;
        logic [7:0]      h2;
        fe_t             r;
        h1 = p[PROD_W-1:FE_W];
        r1 = {8'd0, p[FE_W-1:0]} ^ {9'd0, h1} ^ {h1, 9'd0};
        h2 = r1[FE_W+7:FE_W];
        r  = r1[FE_W-1:0] ^ {105'd0, h2} ^ {96'd0, h2, 9'd0};
        return r;
    endfunction

    function automatic fe_t fe_mul(input fe_t a, input fe_t b);
        logic [PROD_W-1:0] p;
        p = '0;
        for (int i = 0; i < FE_W; i++) begin
            if (b[i]) begin
                p = p ^ ({{(FE_W-1){1'b0}}, a} << i);
            end
        end
        return fe_reduce(p);
    endfunction

    function automatic fe_t fe_sqr(input fe_t a);
        logic [PROD_W-1:0] p;
        p = '0;
        for (int i = 0; i < FE_W; i++) begin
            p[2*i] = a[i];
        end
        return fe_reduce(p);
    endfunction

endpackage

// ===== hw/rtl/gfpa_stage.sv =====
// ----------------------------------------------------------------------------
// gfpa_stage
// One registered pipeline stage: a field multiply or a short squaring run.
// ----------------------------------------------------------------------------
module gfpa_stage
    import gfpa_pkg::*;
#(
    parameter op_t        OP  = OP_SQ,
    parameter logic [3:0] NSQ = 4'd0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [A_W-1:0]   curve_a,
    input  logic             in_valid,
    output logic             in_ready,
    input  word_t            in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output word_t            out_word
);

    logic  valid_reg;
    word_t word_reg;
    word_t word_next;
    fe_t   sq;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb begin
        word_next = in_word;
        sq        = (OP == OP_LOADSQ) ? in_word.acc : in_word.sh;
        case (OP)
            OP_LOADSQ, OP_SQ: begin
                for (int j = 0; j < MAX_SQ; j++) begin
                    if (j < int'(NSQ)) begin
                        sq = fe_sqr(sq);
                    end
                end
                word_next.sh = sq;
            end
            OP_MULAS:  word_next.acc = fe_mul(in_word.acc, in_word.sh);
            OP_SQMULU: word_next.acc = fe_mul(fe_sqr(in_word.acc), in_word.u);
            OP_LAM:    word_next.acc = fe_mul(fe_sqr(in_word.acc), in_word.ys);
            OP_X: begin
                word_next.sh = fe_sqr(in_word.acc) ^ in_word.acc ^ in_word.qx
                             ^ {{(FE_W-A_W){1'b0}}, curve_a};
                word_next.px = word_next.sh ^ in_word.px;
            end
            OP_Y: begin
                word_next.py = fe_mul(in_word.acc, in_word.sh) ^ in_word.px
                             ^ in_word.py;
            end
            default: word_next = in_word;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== hw/rtl/gf2_113_affine_point_add.sv =====
// ----------------------------------------------------------------------------
// gf2_113_affine_point_add
// Affine point addition on a binary curve over GF(2^113).
// ----------------------------------------------------------------------------
// Adds two affine points (x1,y1) + (x2,y2) on y^2 + xy = x^3 + a*x^2 + b over
// GF(2^113), reduction polynomial t^113 + t^9 + 1. The slope denominator
// x1 + x2 is inverted by an Itoh-Tsujii chain (an all-zero denominator gives
// lambda = 0, so the sum is (a, a + y1)); doubling and infinity are not
// detected. The block is a 27-stage pipeline, each stage holding one field
// multiply or up to eight squarings: it takes one word per cycle while the
// output is not stalled. Each stage stalls only when it is full and the next
// one is stalled, so bubbles close up behind a stalled output. curve_a lives
// at byte address 0; the user must write it while idle (no check in the RTL).
// ----------------------------------------------------------------------------
module gf2_113_affine_point_add
    import gfpa_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    // APB config
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // input points
    input  logic          s_tvalid,
    output logic          s_tready,
    // x1_lo, x1_hi, y1_lo, y1_hi, x2_lo, x2_hi, y2_lo, y2_hi, 4 bits zero pad
    input  logic [455:0]  s_tdata,
    // sum point
    output logic          m_tvalid,
    input  logic          m_tready,
    // sum_x_lo, sum_x_hi, sum_y_lo, sum_y_hi, 6 bits zero pad
    output logic [231:0]  m_tdata
);

    localparam logic REG_CURVE_A = 1'b0;

    logic [A_W-1:0] curve_a_reg;
    logic           wr_en;

    // paddr[2] selects the word; only word 0 exists
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CURVE_A) ? curve_a_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_a_reg <= '0;
        end else if (wr_en && paddr[2] == REG_CURVE_A) begin
            curve_a_reg <= pwdata;
        end
    end

    // entry: unpack and form den = x1 + x2, ys = y1 + y2, acc = den
    word_t entry;
    always_comb begin
        entry.px  = s_tdata[112:0];
        entry.py  = s_tdata[225:113];
        entry.qx  = s_tdata[338:226];
        entry.u   = entry.px ^ entry.qx;
        entry.ys  = entry.py ^ s_tdata[451:339];
        entry.acc = entry.u;
        entry.sh  = '0;
    end

    logic  vld [NSTG+1];
    logic  rdy [NSTG+1];
    word_t wrd [NSTG+1];

    assign vld[0]   = s_tvalid;
    assign wrd[0]   = entry;
    assign s_tready = rdy[0];

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        gfpa_stage #(
            .OP  (STG_OP[g]),
            .NSQ (STG_NSQ[g])
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .curve_a   (curve_a_reg),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_word   (wrd[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_word  (wrd[g+1])
        );
    end

    assign rdy[NSTG] = m_tready;
    assign m_tvalid  = vld[NSTG];
    assign m_tdata   = {6'd0, wrd[NSTG].py, wrd[NSTG].px};

endmodule

// ===== hw/rtl/gfpa_checker.sv =====
// ----------------------------------------------------------------------------
// gfpa_checker
// Port-level checks on the point adder, bound to the top level.
// ----------------------------------------------------------------------------
module gfpa_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          psel,
    input logic          penable,
    input logic          pwrite,
    input logic [2:0]    paddr,
    input logic [31:0]   pwdata,
    input logic [31:0]   prdata,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [231:0]  m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // empty output means the pipe can take a word
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // written curve_a reads back
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && paddr[2] == 1'b0
        |=> paddr[2] != 1'b0 || prdata == $past(pwdata))
        else $error("curve_a readback mismatch");

endmodule

bind gf2_113_affine_point_add gfpa_checker u_gfpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/gf2_113_affine_point_add_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf2_113_affine_point_add_tb
// Self-checking bench for the GF(2^113) affine point adder.
// ----------------------------------------------------------------------------
// Point pairs go in over the input stream and the sum points come back over the
// result stream. A bit-level field model in the bench predicts each sum. A queue
// holds the predicted sums, and every result word is compared with the oldest
// one. The run has a directed table first and then random phases, with curve_a
// set to a new value before each group of phases. The sender sends in bursts and the
// receiver stalls on its own pattern. One long receiver hold-off lets the
// pipeline fill up and stall the input.
// ----------------------------------------------------------------------------
module gf2_113_affine_point_add_tb;
    import gfpa_pkg::*;

    localparam int LATENCY   = 27;
    localparam int CYC_LIMIT = 1000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [455:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [231:0] m_tdata;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    gf2_113_affine_point_add DUT (.*);

    typedef struct packed {
        fe_t y2;
        fe_t x2;
        fe_t y1;
        fe_t x1;
    } pts_t;

    // ------------------------------------------------------------------
    // Field model. It is written on its own so that it does not reuse the
    // package functions: a shift-and-add multiply with a bit-by-bit
    // reduction.
    // ------------------------------------------------------------------
    function automatic fe_t gf_mul(fe_t a, fe_t b);
        logic [225:0] p;
        p = '0;
        for (int i = 0; i < FE_W; i++)
            if (b[i]) p ^= {113'd0, a} << i;
        for (int k = 224; k >= FE_W; k--)
            if (p[k]) begin
                p[k] = 1'b0;
                p[k-104] ^= 1'b1;
                p[k-113] ^= 1'b1;
            end
        return p[FE_W-1:0];
    endfunction

    // Raise to 2^113 - 2 by Itoh-Tsujii. A zero input gives zero.
    function automatic fe_t gf_inv(fe_t u);
        fe_t acc, sh;
        int  len;
        acc = u;
        for (int s = 5; s >= 0; s--) begin
            len = 112 >> s;
            sh = acc;
            for (int n = 0; n < len / 2; n++) sh = gf_mul(sh, sh);
            acc = gf_mul(acc, sh);
            if (len % 2) acc = gf_mul(gf_mul(acc, acc), u);
        end
        return gf_mul(acc, acc);
    endfunction

    logic [31:0] curve_a_model;

    // Returns {y3, x3}.
    function automatic logic [2*FE_W-1:0] point_sum(pts_t p);
        fe_t lam, t, sx, sy, ca;
        ca  = {81'd0, curve_a_model};
        lam = gf_mul(p.y1 ^ p.y2, gf_inv(p.x1 ^ p.x2));
        t   = gf_mul(lam, lam) ^ lam ^ p.x2 ^ ca;
        sx  = t ^ p.x1;
        sy  = gf_mul(lam, t) ^ sx ^ p.y1;
        return {sy, sx};
    endfunction

    // the tdata fields are x1, y1, x2, y2 from the lowest bit up
    function automatic logic [455:0] pack_pts(pts_t p);
        return {4'd0, p.y2, p.x2, p.y1, p.x1};
    endfunction

    logic [2*FE_W-1:0] sum_q[$];
    int errors = 0, n_out = 0, n_in = 0, cyc = 0;
    bit timed_out = 0;

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (aresetn && m_tvalid && m_tready) begin
            logic [2*FE_W-1:0] want;
            n_out <= n_out + 1;
            if (sum_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", m_tdata);
            end else begin
                want = sum_q.pop_front();
                if (m_tdata[2*FE_W-1:0] !== want || m_tdata[231:226] !== 6'd0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch x: exp %h got %h | y: exp %h got %h",
                                 want[FE_W-1:0], m_tdata[FE_W-1:0],
                                 want[2*FE_W-1:FE_W], m_tdata[2*FE_W-1:FE_W]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It stalls at random. hold_cnt gives the long hold-off,
    // which is counted here and started by the stimulus process.
    // ------------------------------------------------------------------
    int hold_cnt = 0;
    int stall_pct = 30;
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Offer one point pair, holding it until the DUT accepts it. The burst
    // counter puts random gaps before some of the words; valid drops only
    // for a gap or when the caller stops sending.
    task automatic send_pts(pts_t p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        sum_q.push_back(point_sum(p));
        s_tdata  <= pack_pts(p);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n_in++;
    endtask

    // Let the pipeline run empty, then allow its latency to pass.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sum_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0) curve_a_model = val;
        @(posedge aclk);
    endtask

    task automatic apb_read_check(logic [2:0] addr, logic [31:0] want);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            errors++;
            if (errors <= 10) $display("curve_a read: exp %h got %h", want, prdata);
        end
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic fe_t rand_fe(int mode);
        fe_t f;
        f = fe_t'({$urandom, $urandom, $urandom, $urandom});
        case (mode)
            0: return '0;
            1: return '1;
            2: return fe_t'(1) << $urandom_range(FE_W - 1);
            default: return f;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table. chk = 1 rows carry a sum that can be read off
    // directly: the case of equal x gives lambda 0, so the sum is
    // (a, a + y1).
    // ------------------------------------------------------------------
    typedef struct {
        pts_t              p;
        bit                chk;
        logic [2*FE_W-1:0] sum;
    } row_t;

    row_t dir_tab[$];

    task automatic run_table();
        logic [2*FE_W-1:0] pred;
        foreach (dir_tab[i]) begin
            pred = point_sum(dir_tab[i].p);
            if (dir_tab[i].chk && pred !== dir_tab[i].sum) begin
                errors++;
                if (errors <= 10) $display("directed row %0d: model disagrees", i);
            end
            if (dir_tab[i].chk) begin
                send_pts(dir_tab[i].p);
                sum_q[$] = dir_tab[i].sum;
            end else begin
                send_pts(dir_tab[i].p);
            end
        end
    endtask

    // Mostly pairs with different x, some with equal x, some zero, all-ones or single-bit fields.
    task automatic rand_phase(int n);
        pts_t p;
        repeat (n) begin
            p.x1 = rand_fe(($urandom_range(9) == 0) ? $urandom_range(3) : 3);
            p.y1 = rand_fe(($urandom_range(9) == 0) ? $urandom_range(3) : 3);
            p.y2 = rand_fe(($urandom_range(9) == 0) ? $urandom_range(3) : 3);
            p.x2 = ($urandom_range(19) == 0) ? p.x1 : rand_fe(3);
            send_pts(p);
        end
    endtask

    initial begin : main
        pts_t p;
        fe_t  ones;
        ones = '1;
        curve_a_model = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_read_check(3'd0, 32'd0);

        // With a = 0 and equal x, the sum is (0, y1).
        p = '{default: '0};
        dir_tab.push_back('{p, 1, '0});
        p = '{y2: ones, x2: ones, y1: ones, x1: ones};
        dir_tab.push_back('{p, 1, {ones, 113'd0}});
        p = '{y2: '0, x2: ones, y1: ones, x1: ones};
        dir_tab.push_back('{p, 1, {ones, 113'd0}});
        p = '{y2: '0, x2: '0, y1: '0, x1: ones};
        dir_tab.push_back('{p, 0, '0});
        p = '{y2: ones, x2: '0, y1: '0, x1: ones};
        dir_tab.push_back('{p, 0, '0});
        p = '{y2: '0, x2: fe_t'(1), y1: fe_t'(1), x1: '0};
        dir_tab.push_back('{p, 0, '0});
        p = '{y2: fe_t'(1) << 112, x2: fe_t'(1) << 112, y1: '0, x1: '0};
        dir_tab.push_back('{p, 0, '0});
        for (int i = 0; i < 8; i++) begin
            p = '{rand_fe(3), rand_fe(3), rand_fe(3), rand_fe(3)};
            dir_tab.push_back('{p, 0, '0});
        end
        run_table();
        drain();

        // Same table again with a all ones, then a as a random value.
        apb_write(3'd0, 32'hFFFF_FFFF);
        apb_read_check(3'd0, 32'hFFFF_FFFF);
        foreach (dir_tab[i]) dir_tab[i].chk = 0;
        run_table();
        rand_phase(300);
        drain();

        apb_write(3'd0, $urandom);
        rand_phase(200);
        // The receiver holds off while the sender keeps offering words,
        // so the pipeline fills and stops accepting input.
        burst_left = 200;
        hold_cnt = 150;
        rand_phase(200);
        drain();

        apb_write(3'd0, 32'd1);
        stall_pct = 0;
        rand_phase(300);
        stall_pct = 70;
        rand_phase(300);
        drain();

        apb_write(3'd0, $urandom);
        stall_pct = 30;
        rand_phase(300);
        drain();

        $display("covered %0d point additions and %0d results under 5 curve_a settings",
                 n_in, n_out);
        $display("the run included equal-x cases, extreme fields and a long output stall");
        if (errors == 0 && sum_q.size() == 0)
            $display("gf2_113_affine_point_add_tb passed");
        else
            $display("gf2_113_affine_point_add_tb failed");
        $finish;
    end

    // Watchdog
    always @(posedge aclk) begin
        if (cyc > CYC_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("gf2_113_affine_point_add_tb failed");
            $finish;
        end
    end

endmodule
